// ===== rtl/core/completion_tag_tracker_unit_defines.svh =====
// Assertion macros used by the checker file of the tag tracker.
`ifndef COMPLETION_TAG_TRACKER_UNIT_DEFINES_SVH
`define COMPLETION_TAG_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define CTT_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tag tracker check failed");

// Next-cycle implication, disabled while rst is high.
`define CTT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tag tracker check failed");

`endif

// ===== rtl/core/ctt_pkg.sv =====
package ctt_pkg;

   localparam int SLOT_COUNT_DEFAULT = 64;

   localparam int GEN_W        = 32;
   localparam int QID_W        = 16;
   localparam int SLOT_FIELD_W = 16;
   localparam int FIELD_W      = 16;
   localparam int BYTES_W      = 32;
   localparam int CNT_W        = 64;
   localparam int TOKEN_W      = 64;
   localparam int OP_W         = 3;
   localparam int OUTCOME_W    = 2;
   localparam int PHASE_W      = 2;
   localparam int GROUP_W      = 32;
   localparam int GROUP_POS_W  = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [OP_W-1:0] OP_RESERVE  = 3'd0;
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST     = 3'd2;
   localparam logic [OP_W-1:0] OP_CONSUME  = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE  = 3'd4;

   localparam logic [OUTCOME_W-1:0] OUT_DONE    = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_PENDING = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_STALE   = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_FULL    = 2'd3;

   localparam logic [PHASE_W-1:0] PH_FREE      = 2'd0;
   localparam logic [PHASE_W-1:0] PH_SUBMITTED = 2'd1;
   localparam logic [PHASE_W-1:0] PH_READY     = 2'd2;
   localparam logic [PHASE_W-1:0] PH_CONSUMED  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_QUEUE_ID       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_COMPLETE_CODE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_OK_CODE     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [TOKEN_W-1:0] token;
      logic [FIELD_W-1:0] entry_version;
      logic [FIELD_W-1:0] entry_kind;
      logic [FIELD_W-1:0] entry_status;
      logic [BYTES_W-1:0] entry_bytes;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [TOKEN_W-1:0]   granted_token;
      logic [FIELD_W-1:0]   held_status;
      logic [BYTES_W-1:0]   held_bytes;
      logic [CNT_W-1:0]     stale_total;
      logic [CNT_W-1:0]     completed_total;
      logic [CNT_W-1:0]     failed_total;
   } rsp_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [GEN_W-1:0]   generation;
      logic [FIELD_W-1:0] status;
      logic [BYTES_W-1:0] bytes;
   } slot_entry_type;

   typedef struct packed {
      logic take;
      logic give;
   } map_upd_type;

endpackage

// ===== rtl/core/ctt_slot_ram.sv =====
// Slot table: one write port, one read port, registered read data.
module ctt_slot_ram #(
   parameter int SLOT_COUNT = ctt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(SLOT_COUNT)-1:0]  wr_addr,
   input  ctt_pkg::slot_entry_type        wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(SLOT_COUNT)-1:0]  rd_addr,
   output ctt_pkg::slot_entry_type        rd_data
);

   ctt_pkg::slot_entry_type slot_mem_ff [SLOT_COUNT];
   ctt_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ctt_free_finder.sv =====
// Bitmap of slots open for reserve (free or consumed) and a two-level
// lowest-index search. The per-group level is registered, so an update
// presented on upd passes the bitmap register and then the per-group registers before it shows at the outputs.
module ctt_free_finder #(
   parameter int SLOT_COUNT = ctt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctt_pkg::map_upd_type           upd,
   input  logic [$clog2(SLOT_COUNT)-1:0]  upd_idx,
   output logic                           found,
   output logic [$clog2(SLOT_COUNT)-1:0]  found_idx
);

   localparam int IDX_W     = $clog2(SLOT_COUNT);
   localparam int GROUPS    = (SLOT_COUNT + ctt_pkg::GROUP_W - 1) / ctt_pkg::GROUP_W;
   localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_W     = GROUPS * ctt_pkg::GROUP_W;
   localparam int PICK_W    = GRP_IDX_W + ctt_pkg::GROUP_POS_W;

   logic [SLOT_COUNT-1:0]               avail_ff;
   logic [SLOT_COUNT-1:0]               avail_in;
   logic [PAD_W-1:0]                    avail_pad;
   logic [GROUPS-1:0]                   grp_any_ff;
   logic [GROUPS-1:0]                   grp_any_in;
   logic [ctt_pkg::GROUP_POS_W-1:0]     grp_pos_ff [GROUPS];
   logic [ctt_pkg::GROUP_POS_W-1:0]     grp_pos_in [GROUPS];
   logic [PICK_W-1:0]                   pick;

   assign avail_pad = PAD_W'(avail_ff);

   always_comb begin
      avail_in = avail_ff;
      if (upd.take) begin
         avail_in[upd_idx] = 1'b0;
      end
      if (upd.give) begin
         avail_in[upd_idx] = 1'b1;
      end
   end

   // First level: lowest open position inside each group of slots.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = |avail_pad[g*ctt_pkg::GROUP_W +: ctt_pkg::GROUP_W];
         grp_pos_in[g] = '0;
         for (int j = ctt_pkg::GROUP_W - 1; j >= 0; j--) begin
            if (avail_pad[g*ctt_pkg::GROUP_W + j]) begin
               grp_pos_in[g] = ctt_pkg::GROUP_POS_W'(j);
            end
         end
      end
   end

   // Second level: lowest group that has an open slot.
   always_comb begin
      pick = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick = {GRP_IDX_W'(g), grp_pos_ff[g]};
         end
      end
   end

   assign found     = |grp_any_ff;
   assign found_idx = pick[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff   <= '1;
         grp_any_ff <= '1;
         for (int g = 0; g < GROUPS; g++) begin
            grp_pos_ff[g] <= '0;
         end
      end else begin
         avail_ff   <= avail_in;
         grp_any_ff <= grp_any_in;
         for (int g = 0; g < GROUPS; g++) begin
            grp_pos_ff[g] <= grp_pos_in[g];
         end
      end
   end

endmodule

// ===== rtl/core/completion_tag_tracker_unit.sv =====
// One request is taken at a time; its response is registered once the response register
// can take it. The next request waits for the read-modify-write of the slot table memory,
// and after a reserve that claims a slot, a consume of a ready slot or a matching release,
// also for its bitmap update to pass the registered free-slot search.
// Reset is synchronous and active high; it frees all slots, zeroes the generations
// and counters and loads the register defaults at once, with no clearing pass.
module completion_tag_tracker_unit #(
   parameter int SLOT_COUNT = ctt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ctt_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ctt_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [ctt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ctt_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int FILL_W = $clog2(SLOT_COUNT + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DATA   = 2'd1;
   localparam logic [1:0] ST_SETTLE = 2'd2;

   // Control state.
   logic [1:0]                      state_ff;
   logic [1:0]                      state_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;

   // Configuration registers.
   logic [ctt_pkg::QID_W-1:0]       own_qid_ff;
   logic [ctt_pkg::FIELD_W-1:0]     exp_ver_ff;
   logic [ctt_pkg::FIELD_W-1:0]     rd_code_ff;
   logic [ctt_pkg::FIELD_W-1:0]     ok_code_ff;

   // Counters and the high-water mark of slots ever reserved.
   logic [ctt_pkg::CNT_W-1:0]       stale_cnt_ff;
   logic [ctt_pkg::CNT_W-1:0]       stale_cnt_in;
   logic [ctt_pkg::CNT_W-1:0]       done_cnt_ff;
   logic [ctt_pkg::CNT_W-1:0]       done_cnt_in;
   logic [ctt_pkg::CNT_W-1:0]       fail_cnt_ff;
   logic [ctt_pkg::CNT_W-1:0]       fail_cnt_in;
   logic [FILL_W-1:0]               fill_ff;
   logic [FILL_W-1:0]               fill_in;

   // Request held across the read.
   ctt_pkg::req_type                req_ff;
   logic [IDX_W-1:0]                addr_ff;
   logic                            found_ff;
   logic                            beyond_ff;
   ctt_pkg::rsp_type                rsp_data_ff;
   ctt_pkg::rsp_type                rsp_data_in;

   logic                            req_accept;
   logic                            fire;
   logic [IDX_W-1:0]                rd_addr;
   logic                            find_found;
   logic [IDX_W-1:0]                find_idx;
   ctt_pkg::slot_entry_type         rd_entry;
   ctt_pkg::slot_entry_type         ent;
   ctt_pkg::slot_entry_type         wr_entry;
   logic                            wr_en;
   ctt_pkg::map_upd_type            map_upd;

   // Token fields of the held request.
   logic [ctt_pkg::GEN_W-1:0]        tok_gen;
   logic [ctt_pkg::QID_W-1:0]        tok_qid;
   logic [ctt_pkg::SLOT_FIELD_W-1:0] tok_slot;
   logic                             in_range;
   logic                             lookup_hit;
   logic                             entry_ok;
   logic [ctt_pkg::GEN_W-1:0]        gen_next;

   // The block works on one request at a time. It stalls the input whenever
   // it is not idle; a finished response may still be waiting downstream
   // while the next request is read.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The response register must be empty, or emptying, before the slot
   // table is written back and the new response is loaded.
   assign fire = (state_ff == ST_DATA) && !(rsp_valid_ff && rsp_stall);

   // A reserve reads the lowest open slot; every other opcode reads the slot
   // named by the token. A token slot past the table is masked by the range
   // check later, so the truncated address is harmless.
   assign rd_addr = (req_data.opcode == ctt_pkg::OP_RESERVE) ? find_idx
                                                            : req_data.token[IDX_W-1:0];

   ctt_slot_ram #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_entry),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   ctt_free_finder #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_free_finder (
      .clock     (clock),
      .reset     (reset),
      .upd       (map_upd),
      .upd_idx   (addr_ff),
      .found     (find_found),
      .found_idx (find_idx)
   );

   assign tok_gen  = req_ff.token[ctt_pkg::TOKEN_W-1 -: ctt_pkg::GEN_W];
   assign tok_qid  = req_ff.token[ctt_pkg::SLOT_FIELD_W +: ctt_pkg::QID_W];
   assign tok_slot = req_ff.token[ctt_pkg::SLOT_FIELD_W-1:0];
   assign in_range = (tok_slot < ctt_pkg::SLOT_FIELD_W'(SLOT_COUNT));

   // Reserve always takes the lowest open slot, so the slots that were ever
   // written form a prefix of the table. An entry at or above the fill mark
   // has never been written and reads as its reset value: free, generation
   // zero. This stands in for clearing the memory after reset.
   always_comb begin
      if (beyond_ff) begin
         ent.phase      = ctt_pkg::PH_FREE;
         ent.generation = '0;
         ent.status     = '0;
         ent.bytes      = '0;
      end else begin
         ent = rd_entry;
      end
   end

   assign lookup_hit = (tok_qid == own_qid_ff) && in_range && (ent.generation == tok_gen);
   assign entry_ok   = (req_ff.entry_version == exp_ver_ff) &&
                       (req_ff.entry_kind == rd_code_ff) && lookup_hit &&
                       (ent.phase == ctt_pkg::PH_SUBMITTED);

   // A new generation never takes the value zero, so a zero token cannot
   // name a live reservation.
   always_comb begin
      gen_next = ent.generation + ctt_pkg::GEN_W'(1);
      if (gen_next == '0) begin
         gen_next = ctt_pkg::GEN_W'(1);
      end
   end

   // Read-modify-write of the addressed slot and the response.
   always_comb begin
      wr_entry     = ent;
      wr_en        = 1'b0;
      map_upd.take = 1'b0;
      map_upd.give = 1'b0;
      stale_cnt_in = stale_cnt_ff;
      done_cnt_in  = done_cnt_ff;
      fail_cnt_in  = fail_cnt_ff;
      fill_in      = fill_ff;

      rsp_data_in.outcome         = ctt_pkg::OUT_STALE;
      rsp_data_in.granted_token   = '0;
      rsp_data_in.held_status     = '0;
      rsp_data_in.held_bytes      = '0;

      unique case (req_ff.opcode) inside
         ctt_pkg::OP_RESERVE: begin
            if (found_ff) begin
               wr_entry.phase      = ctt_pkg::PH_SUBMITTED;
               wr_entry.generation = gen_next;
               wr_entry.status     = '0;
               wr_entry.bytes      = '0;
               wr_en               = 1'b1;
               map_upd.take        = 1'b1;
               if (FILL_W'(addr_ff) == fill_ff) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               rsp_data_in.outcome       = ctt_pkg::OUT_DONE;
               rsp_data_in.granted_token = {gen_next, own_qid_ff,
                                            ctt_pkg::SLOT_FIELD_W'(addr_ff)};
            end else begin
               rsp_data_in.outcome = ctt_pkg::OUT_FULL;
            end
         end
         ctt_pkg::OP_COMPLETE: begin
            if (entry_ok) begin
               wr_entry.phase  = ctt_pkg::PH_READY;
               wr_entry.status = req_ff.entry_status;
               wr_entry.bytes  = req_ff.entry_bytes;
               wr_en           = 1'b1;
               done_cnt_in     = done_cnt_ff + ctt_pkg::CNT_W'(1);
               if (req_ff.entry_status != ok_code_ff) begin
                  fail_cnt_in = fail_cnt_ff + ctt_pkg::CNT_W'(1);
               end
               rsp_data_in.outcome = ctt_pkg::OUT_DONE;
            end else begin
               stale_cnt_in = stale_cnt_ff + ctt_pkg::CNT_W'(1);
            end
         end
         ctt_pkg::OP_TEST, ctt_pkg::OP_CONSUME: begin
            if (lookup_hit && (ent.phase == ctt_pkg::PH_SUBMITTED)) begin
               rsp_data_in.outcome = ctt_pkg::OUT_PENDING;
            end else if (lookup_hit && (ent.phase == ctt_pkg::PH_READY)) begin
               rsp_data_in.outcome     = ctt_pkg::OUT_DONE;
               rsp_data_in.held_status = ent.status;
               rsp_data_in.held_bytes  = ent.bytes;
               if (req_ff.opcode == ctt_pkg::OP_CONSUME) begin
                  wr_entry.phase = ctt_pkg::PH_CONSUMED;
                  wr_en          = 1'b1;
                  map_upd.give   = 1'b1;
               end
            end
         end
         ctt_pkg::OP_RELEASE: begin
            // Any phase goes back to free; the generation is kept so that
            // the next reserve of this slot moves past it.
            if (lookup_hit) begin
               wr_entry.phase      = ctt_pkg::PH_FREE;
               wr_en               = 1'b1;
               map_upd.give        = 1'b1;
               rsp_data_in.outcome = ctt_pkg::OUT_DONE;
            end
         end
         default: begin
            // Unused opcodes leave the table and the counters alone.
         end
      endcase

      // Nothing is committed until the response register can take the result.
      if (!fire) begin
         wr_en        = 1'b0;
         map_upd.take = 1'b0;
         map_upd.give = 1'b0;
         stale_cnt_in = stale_cnt_ff;
         done_cnt_in  = done_cnt_ff;
         fail_cnt_in  = fail_cnt_ff;
         fill_in      = fill_ff;
      end

      rsp_data_in.stale_total     = stale_cnt_in;
      rsp_data_in.completed_total = done_cnt_in;
      rsp_data_in.failed_total    = fail_cnt_in;
   end

   // Sequencer. After a bitmap change it passes through the settle state so that
   // the registered search result covers the new bitmap before the next request.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (fire) begin
               state_in = (map_upd.take || map_upd.give) ? ST_SETTLE : ST_IDLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         stale_cnt_ff <= '0;
         done_cnt_ff  <= '0;
         fail_cnt_ff  <= '0;
         fill_ff      <= '0;
         own_qid_ff   <= ctt_pkg::QID_W'(0);
         exp_ver_ff   <= ctt_pkg::FIELD_W'(1);
         rd_code_ff   <= ctt_pkg::FIELD_W'(1);
         ok_code_ff   <= ctt_pkg::FIELD_W'(0);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stale_cnt_ff <= stale_cnt_in;
         done_cnt_ff  <= done_cnt_in;
         fail_cnt_ff  <= fail_cnt_in;
         fill_ff      <= fill_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               ctt_pkg::CSR_OWN_QUEUE_ID:       own_qid_ff <= csr_wr_data;
               ctt_pkg::CSR_EXPECTED_VERSION:   exp_ver_ff <= csr_wr_data;
               ctt_pkg::CSR_READ_COMPLETE_CODE: rd_code_ff <= csr_wr_data;
               ctt_pkg::CSR_STATUS_OK_CODE:     ok_code_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Request and response payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff    <= req_data;
         addr_ff   <= rd_addr;
         found_ff  <= find_found;
         beyond_ff <= (FILL_W'(rd_addr) >= fill_ff);
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/ctt_checker.sv =====
`include "completion_tag_tracker_unit_defines.svh"

module ctt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // One request at a time: the input is closed right after an accept.
   `CTT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A new response only comes out of a cycle in which the block was busy.
   `CTT_ASSERT_IMPLY(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // A waiting response is not withdrawn.
   `CTT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Reset leaves the block empty and ready.
   `CTT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind completion_tag_tracker_unit ctt_checker u_ctt_checker (.*);
